/* src/mbce_pkg.sv */
package mbce_pkg;

   localparam int WORD_BITS = 16;
   localparam int POS_W     = $clog2(WORD_BITS);
   localparam int CNT_W     = $clog2(WORD_BITS + 1);
   localparam int BYTES_PER_PIXEL = 4;
   localparam int ADDR_W    = 5;
   localparam int DIM_W     = 13;
   localparam int PITCH_W   = 16;

   typedef enum logic [2:0] {
      REG_FG_COLOR       = 3'd0,
      REG_BG_COLOR       = 3'd1,
      REG_USE_BACKGROUND = 3'd2,
      REG_START_BIT      = 3'd3,
      REG_ROW_WIDTH      = 3'd4,
      REG_ROW_COUNT      = 3'd5,
      REG_DEST_START     = 3'd6,
      REG_DEST_PITCH     = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_READY,
      ST_PIXEL,
      ST_IDLE,
      ST_SKIP
   } state_type;

   typedef struct packed {
      logic [31:0]        fg_color;
      logic [31:0]        bg_color;
      logic               use_background;
      logic [POS_W-1:0]   start_bit;
      logic [DIM_W-1:0]   row_width;
      logic [DIM_W-1:0]   row_count;
      logic [31:0]        dest_start;
      logic [PITCH_W-1:0] dest_pitch;
   } cfg_type;

   typedef struct packed {
      logic        restart;
      logic [31:0] restart_addr;
      logic        advance;
      logic        next_row;
   } trk_cmd_type;

   typedef struct packed {
      logic [DIM_W-1:0] column_index;
      logic [DIM_W-1:0] row_index;
      logic [31:0]      pixel_address;
      logic [31:0]      row_address;
      logic             row_last;
      logic             block_last;
      logic             block_over;
   } trk_stat_type;

endpackage

/* src/mbce_csr.sv */
module mbce_csr
   import mbce_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output cfg_type           cfg,
   output logic              restart,
   output logic [31:0]       restart_addr
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // every write restarts the block, from the newly written start if that is the target
   assign restart      = wr_en;
   assign restart_addr = (index == REG_DEST_START) ? pwdata : cfg_ff.dest_start;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_FG_COLOR:       cfg_in.fg_color       = pwdata;
            REG_BG_COLOR:       cfg_in.bg_color       = pwdata;
            REG_USE_BACKGROUND: cfg_in.use_background = pwdata[0];
            REG_START_BIT:      cfg_in.start_bit      = pwdata[POS_W-1:0];
            REG_ROW_WIDTH:      cfg_in.row_width      = pwdata[DIM_W-1:0];
            REG_ROW_COUNT:      cfg_in.row_count      = pwdata[DIM_W-1:0];
            REG_DEST_START:     cfg_in.dest_start     = pwdata;
            REG_DEST_PITCH:     cfg_in.dest_pitch     = pwdata[PITCH_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_FG_COLOR:       prdata = cfg_ff.fg_color;
         REG_BG_COLOR:       prdata = cfg_ff.bg_color;
         REG_USE_BACKGROUND: prdata = {31'd0, cfg_ff.use_background};
         REG_START_BIT:      prdata = {{(32-POS_W){1'b0}}, cfg_ff.start_bit};
         REG_ROW_WIDTH:      prdata = {{(32-DIM_W){1'b0}}, cfg_ff.row_width};
         REG_ROW_COUNT:      prdata = {{(32-DIM_W){1'b0}}, cfg_ff.row_count};
         REG_DEST_START:     prdata = cfg_ff.dest_start;
         REG_DEST_PITCH:     prdata = {{(32-PITCH_W){1'b0}}, cfg_ff.dest_pitch};
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{row_width: DIM_W'(1), default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/mbce_bit_shifter.sv */
module mbce_bit_shifter
   import mbce_pkg::*;
(
   input  logic                 clock,
   input  logic                 load,
   input  logic                 shift,
   input  logic [WORD_BITS-1:0] word,
   input  logic [POS_W-1:0]     pos,
   output logic                 bit_out
);

   logic [WORD_BITS-1:0] data_ff, data_in;

   // first pixel of the request is aligned to the msb on load
   always_comb begin
      data_in = data_ff;
      if (load) begin
         data_in = word << pos;
      end else if (shift) begin
         data_in = {data_ff[WORD_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign bit_out = data_ff[WORD_BITS-1];

endmodule

/* src/mbce_pos_track.sv */
module mbce_pos_track
   import mbce_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  trk_cmd_type  cmd,
   output trk_stat_type stat
);

   logic [DIM_W-1:0] column_index_ff, column_index_in;
   logic [DIM_W-1:0] row_index_ff, row_index_in;
   logic [31:0]      pixel_address_ff, pixel_address_in;
   logic [31:0]      row_address_ff, row_address_in;
   logic [31:0]      row_sum;

   assign row_sum = row_address_ff + {{(32-PITCH_W){1'b0}}, cfg.dest_pitch};

   always_comb begin
      column_index_in  = column_index_ff;
      row_index_in     = row_index_ff;
      pixel_address_in = pixel_address_ff;
      row_address_in   = row_address_ff;
      if (cmd.restart) begin
         column_index_in  = '0;
         row_index_in     = '0;
         pixel_address_in = cmd.restart_addr;
         row_address_in   = cmd.restart_addr;
      end else if (cmd.next_row) begin
         column_index_in  = '0;
         row_index_in     = row_index_ff + DIM_W'(1);
         pixel_address_in = row_sum;
         row_address_in   = row_sum;
      end else if (cmd.advance) begin
         column_index_in  = column_index_ff + DIM_W'(1);
         pixel_address_in = pixel_address_ff + 32'(BYTES_PER_PIXEL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_index_ff  <= '0;
         row_index_ff     <= '0;
         pixel_address_ff <= '0;
         row_address_ff   <= '0;
      end else begin
         column_index_ff  <= column_index_in;
         row_index_ff     <= row_index_in;
         pixel_address_ff <= pixel_address_in;
         row_address_ff   <= row_address_in;
      end
   end

   always_comb begin
      stat.column_index  = column_index_ff;
      stat.row_index     = row_index_ff;
      stat.pixel_address = pixel_address_ff;
      stat.row_address   = row_address_ff;
      stat.row_last      = ({1'b0, column_index_ff} + (DIM_W+1)'(1))
                           >= {1'b0, cfg.row_width};
      stat.block_last    = ({1'b0, row_index_ff} + (DIM_W+1)'(1))
                           >= {1'b0, cfg.row_count};
      stat.block_over    = row_index_ff >= cfg.row_count;
   end

endmodule

/* src/mono_bitmap_color_expand_core.sv */
// monochrome colour expansion: each accepted request carries one 16-bit bitmap word,
// msb leftmost, and yields one pixel result per cycle while the result side does not
// stall: the foreground colour for a set bit, the background colour (or a skipped
// write when background use is off) for a clear bit, each with its byte address,
// stepping by 4 per pixel and by the pitch per row. a row's first word starts at the
// configured start bit; bits past the row's end are dropped. a word that yields n
// pixels (n up to 16) holds off further requests until its last pixel is sent; the
// shift register feeding the colour select moves one bit per pixel sent. once all rows
// are drawn, or when the row width is zero, a word gives a single result. any register
// write restarts the block at the top-left pixel. the user must write the registers
// over the apb port only while no request is in flight; the block does not enforce it
module mono_bitmap_color_expand_core
   import mbce_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WORD_BITS-1:0] req_source_word,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_dest_address,
   output logic [31:0]          rsp_pixel_value,
   output logic                 rsp_write_enable,
   output logic                 rsp_row_end,
   output logic                 rsp_block_done,
   output logic                 rsp_last_of_item,
   // register port
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_W-1:0]    paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   cfg_type      cfg;
   logic         restart;
   logic [31:0]  restart_addr;
   trk_cmd_type  cmd;
   trk_stat_type stat;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             accept;
   logic             out_free;
   logic             emit;
   logic             load;
   logic             pixel_bit;
   logic [POS_W-1:0] pos;
   logic [DIM_W-1:0] left;
   logic [CNT_W-1:0] avail;
   logic [CNT_W-1:0] n_pixels;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_dest_address_ff, rsp_dest_address_in;
   logic [31:0] rsp_pixel_value_ff, rsp_pixel_value_in;
   logic        rsp_write_enable_ff, rsp_write_enable_in;
   logic        rsp_row_end_ff, rsp_row_end_in;
   logic        rsp_block_done_ff, rsp_block_done_in;
   logic        rsp_last_of_item_ff, rsp_last_of_item_in;

   mbce_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .cfg          (cfg),
      .restart      (restart),
      .restart_addr (restart_addr)
   );

   mbce_pos_track u_pos_track (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .cmd   (cmd),
      .stat  (stat)
   );

   mbce_bit_shifter u_bit_shifter (
      .clock   (clock),
      .load    (load),
      .shift   (emit),
      .word    (req_source_word),
      .pos     (pos),
      .bit_out (pixel_bit)
   );

   // one request at a time; the output register decouples the result side
   assign req_stall = (state_ff != ST_READY);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign emit      = (state_ff != ST_READY) & out_free;

   // only a row's first word starts at the configured bit
   assign pos   = (stat.column_index == '0) ? cfg.start_bit : '0;
   assign left  = cfg.row_width - stat.column_index;
   assign avail = CNT_W'(WORD_BITS) - CNT_W'(pos);
   assign n_pixels = ({{(DIM_W-CNT_W){1'b0}}, avail} > left) ? CNT_W'(left) : avail;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      load     = 1'b0;
      unique case (state_ff)
         ST_READY: begin
            if (accept) begin
               if (stat.block_over) begin
                  state_in = ST_IDLE;
               end else if (cfg.row_width == '0) begin
                  state_in = ST_SKIP;
               end else begin
                  state_in = ST_PIXEL;
                  count_in = n_pixels;
                  load     = 1'b1;
               end
            end
         end
         ST_PIXEL: begin
            if (emit) begin
               count_in = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = ST_READY;
               end
            end
         end
         ST_IDLE, ST_SKIP: begin
            if (emit) begin
               state_in = ST_READY;
            end
         end
         default: state_in = ST_READY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_READY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

   // position tracking commands
   always_comb begin
      cmd.restart      = restart;
      cmd.restart_addr = restart_addr;
      cmd.advance      = emit & (state_ff == ST_PIXEL) & ~stat.row_last;
      cmd.next_row     = emit & (((state_ff == ST_PIXEL) & stat.row_last)
                                 | (state_ff == ST_SKIP));
   end

   // result formation
   always_comb begin
      rsp_valid_in        = rsp_valid_ff & rsp_stall;
      rsp_dest_address_in = rsp_dest_address_ff;
      rsp_pixel_value_in  = rsp_pixel_value_ff;
      rsp_write_enable_in = rsp_write_enable_ff;
      rsp_row_end_in      = rsp_row_end_ff;
      rsp_block_done_in   = rsp_block_done_ff;
      rsp_last_of_item_in = rsp_last_of_item_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         unique case (state_ff)
            ST_PIXEL: begin
               rsp_dest_address_in = stat.pixel_address;
               rsp_write_enable_in = pixel_bit | cfg.use_background;
               rsp_pixel_value_in  = pixel_bit ? cfg.fg_color :
                                     (cfg.use_background ? cfg.bg_color : 32'd0);
               rsp_row_end_in      = stat.row_last;
               rsp_block_done_in   = stat.row_last & stat.block_last;
               rsp_last_of_item_in = (count_ff == CNT_W'(1));
            end
            ST_SKIP: begin
               // zero-width row: one skipped write at the row start
               rsp_dest_address_in = stat.row_address;
               rsp_write_enable_in = 1'b0;
               rsp_pixel_value_in  = 32'd0;
               rsp_row_end_in      = 1'b1;
               rsp_block_done_in   = stat.block_last;
               rsp_last_of_item_in = 1'b1;
            end
            default: begin
               // block finished: idle result
               rsp_dest_address_in = stat.pixel_address;
               rsp_write_enable_in = 1'b0;
               rsp_pixel_value_in  = 32'd0;
               rsp_row_end_in      = 1'b0;
               rsp_block_done_in   = 1'b1;
               rsp_last_of_item_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_dest_address_ff <= rsp_dest_address_in;
      rsp_pixel_value_ff  <= rsp_pixel_value_in;
      rsp_write_enable_ff <= rsp_write_enable_in;
      rsp_row_end_ff      <= rsp_row_end_in;
      rsp_block_done_ff   <= rsp_block_done_in;
      rsp_last_of_item_ff <= rsp_last_of_item_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dest_address = rsp_dest_address_ff;
   assign rsp_pixel_value  = rsp_pixel_value_ff;
   assign rsp_write_enable = rsp_write_enable_ff;
   assign rsp_row_end      = rsp_row_end_ff;
   assign rsp_block_done   = rsp_block_done_ff;
   assign rsp_last_of_item = rsp_last_of_item_ff;

   // a pixel run always holds at least one pixel still to send
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PIXEL |-> count_ff != '0)
      else $error("pixel run with empty count");

   // the final pixel of a request is flagged as such
   assert property (@(posedge clock) disable iff (reset)
      (emit && state_ff == ST_PIXEL && count_ff == CNT_W'(1)) |=>
         (rsp_valid_ff && rsp_last_of_item_ff))
      else $error("last pixel of request not flagged");

   // a skipped or idle result carries no colour
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_write_enable_ff || rsp_pixel_value_ff == 32'd0))
      else $error("colour on skipped result");

   // a written pixel can only end the block on the end of a row
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_write_enable_ff && rsp_block_done_ff) |-> rsp_row_end_ff)
      else $error("block done off a row end");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top
   import mbce_pkg::*;
;

   // run limits: the hang stop sits far above the slowest correct run
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_WORDS = 210;
   localparam int MAX_BURST    = 30;
   localparam int REPORT_LIMIT = 10;

   // one pixel write as it leaves the block
   typedef struct packed {
      logic [31:0] dest_address;
      logic [31:0] pixel_value;
      logic        write_enable;
      logic        row_end;
      logic        block_done;
      logic        last_of_item;
   } pixel_write_type;

   // predicts the pixel writes of each bitmap word and checks them in order
   class expansion_scoreboard;
      logic [31:0]        fg_color;
      logic [31:0]        bg_color;
      logic               use_background;
      logic [POS_W-1:0]   start_bit;
      logic [DIM_W-1:0]   row_width;
      logic [DIM_W-1:0]   row_count;
      logic [31:0]        dest_start;
      logic [PITCH_W-1:0] dest_pitch;
      logic [DIM_W-1:0]   column_index;
      logic [DIM_W-1:0]   row_index;
      logic [31:0]        row_address;
      logic [31:0]        pixel_address;
      pixel_write_type    expected_pixels[$];
      int                 mismatches;
      int                 pixels_checked;
      int                 quiet_results;

      function new();
         fg_color       = '0;
         bg_color       = '0;
         use_background = 1'b0;
         start_bit      = '0;
         row_width      = DIM_W'(1);
         row_count      = '0;
         dest_start     = '0;
         dest_pitch     = '0;
         mismatches     = 0;
         pixels_checked = 0;
         quiet_results  = 0;
         restart();
      endfunction

      function void restart();
         column_index  = '0;
         row_index     = '0;
         row_address   = dest_start;
         pixel_address = dest_start;
      endfunction

      function void step_row();
         row_index     = row_index + DIM_W'(1);
         row_address   = row_address + 32'(dest_pitch);
         pixel_address = row_address;
         column_index  = '0;
      endfunction

      function void set_register(reg_index_type idx, logic [31:0] value);
         case (idx)
            REG_FG_COLOR:       fg_color       = value;
            REG_BG_COLOR:       bg_color       = value;
            REG_USE_BACKGROUND: use_background = value[0];
            REG_START_BIT:      start_bit      = value[POS_W-1:0];
            REG_ROW_WIDTH:      row_width      = value[DIM_W-1:0];
            REG_ROW_COUNT:      row_count      = value[DIM_W-1:0];
            REG_DEST_START:     dest_start     = value;
            REG_DEST_PITCH:     dest_pitch     = value[PITCH_W-1:0];
            default: ;
         endcase
         restart();
      endfunction

      // expand one accepted bitmap word into its expected pixel writes
      function void take_word(logic [WORD_BITS-1:0] word);
         pixel_write_type px;
         int              pos;
         int              span;
         logic            row_last;
         logic            row_done;
         if (int'(row_index) >= int'(row_count)) begin
            // block over: one idle result at the current pixel
            px = '{pixel_address, 32'd0, 1'b0, 1'b0, 1'b1, 1'b1};
            expected_pixels.push_back(px);
            return;
         end
         if (row_width == '0) begin
            // empty row: one skip at the row start, then on to the next row
            row_done = int'(row_index) + 1 >= int'(row_count);
            px = '{row_address, 32'd0, 1'b0, 1'b1, row_done, 1'b1};
            expected_pixels.push_back(px);
            step_row();
            return;
         end
         pos  = (column_index == '0) ? int'(start_bit) : 0;
         span = WORD_BITS - pos;
         if (span > int'(row_width) - int'(column_index))
            span = int'(row_width) - int'(column_index);
         for (int k = 0; k < span; k++) begin
            if (word[WORD_BITS-1-(pos+k)]) begin
               px.pixel_value  = fg_color;
               px.write_enable = 1'b1;
            end else if (use_background) begin
               px.pixel_value  = bg_color;
               px.write_enable = 1'b1;
            end else begin
               px.pixel_value  = '0;
               px.write_enable = 1'b0;
            end
            row_last          = int'(column_index) + 1 >= int'(row_width);
            px.dest_address   = pixel_address;
            px.row_end        = row_last;
            px.block_done     = row_last && (int'(row_index) + 1 >= int'(row_count));
            px.last_of_item   = (k == span - 1);
            expected_pixels.push_back(px);
            if (row_last) begin
               step_row();
            end else begin
               column_index  = column_index + DIM_W'(1);
               pixel_address = pixel_address + 32'(BYTES_PER_PIXEL);
            end
         end
      endfunction

      function void report(string what, pixel_write_type want, pixel_write_type got);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%s at %0t: expected addr=%h val=%h we=%b re=%b bd=%b last=%b",
                     what, $time, want.dest_address, want.pixel_value, want.write_enable,
                     want.row_end, want.block_done, want.last_of_item);
            $display("   got addr=%h val=%h we=%b re=%b bd=%b last=%b",
                     got.dest_address, got.pixel_value, got.write_enable,
                     got.row_end, got.block_done, got.last_of_item);
         end
      endfunction

      function void check_pixel(pixel_write_type got);
         pixel_write_type want;
         pixels_checked++;
         if (!got.write_enable)
            quiet_results++;
         if (expected_pixels.size() == 0) begin
            report("unexpected result", '0, got);
            return;
         end
         want = expected_pixels.pop_front();
         if (got !== want)
            report("pixel mismatch", want, got);
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   // clock, reset and every block input start at known values
   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic [WORD_BITS-1:0] req_source_word = '0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [31:0]          rsp_dest_address;
   logic [31:0]          rsp_pixel_value;
   logic                 rsp_write_enable;
   logic                 rsp_row_end;
   logic                 rsp_block_done;
   logic                 rsp_last_of_item;
   logic                 psel            = 1'b0;
   logic                 penable         = 1'b0;
   logic                 pwrite          = 1'b0;
   logic [ADDR_W-1:0]    paddr           = '0;
   logic [31:0]          pwdata          = '0;
   logic [31:0]          prdata;
   logic                 pready;

   expansion_scoreboard expansion;

   // idling controls, switched per phase
   bit gaps_on    = 1'b0;
   bit stalls_on  = 1'b0;
   int stall_left = 0;

   // run statistics for the summary
   int words_sent    = 0;
   int random_words  = 0;
   int settings_used = 0;

   mono_bitmap_color_expand_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_source_word  (req_source_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dest_address (rsp_dest_address),
      .rsp_pixel_value  (rsp_pixel_value),
      .rsp_write_enable (rsp_write_enable),
      .rsp_row_end      (rsp_row_end),
      .rsp_block_done   (rsp_block_done),
      .rsp_last_of_item (rsp_last_of_item),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // gap length: mostly from the short range, now and then from the long range
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   // source words one row of the given start bit and width takes
   function automatic int words_per_row(int first_bit, int width);
      int first_span;
      if (width == 0)
         return 1;
      first_span = WORD_BITS - first_bit;
      if (width <= first_span)
         return 1;
      return 1 + (width - first_span + WORD_BITS - 1) / WORD_BITS;
   endfunction

   // both handshakes are sampled at the rising edge in one process, so a
   // request and a result at the same edge are always seen in the same order
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            expansion.take_word(req_source_word);
         if (rsp_valid && !rsp_stall)
            expansion.check_pixel('{rsp_dest_address, rsp_pixel_value, rsp_write_enable,
                                    rsp_row_end, rsp_block_done, rsp_last_of_item});
      end
   end

   // result-side back-pressure, changed only at the falling edge
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (stalls_on && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
      end
   end

   // one request: optional gap, then hold valid and the word until accepted.
   // valid stays high afterwards so back-to-back requests need no gap
   task automatic send_word(input logic [WORD_BITS-1:0] word);
      int gap;
      gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_source_word <= word;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // drop valid, then wait until every expected pixel is checked and the block drains
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expansion.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // apb write: setup cycle, then access cycle until pready
   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      expansion.set_register(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // random register setting: most rows narrow, a few wide or empty
   task automatic random_setting();
      logic [31:0] value;
      int          pick;
      for (int i = 0; i < 8; i++) begin
         if ($urandom_range(0, 4) != 0) begin
            case (reg_index_type'(i))
               REG_ROW_WIDTH: begin
                  pick = $urandom_range(0, 19);
                  if (pick == 0)
                     value = 0;
                  else if (pick <= 2)
                     value = $urandom_range(40, 120);
                  else if (pick == 3)
                     value = 8191;
                  else
                     value = $urandom_range(1, 24);
               end
               REG_ROW_COUNT:
                  value = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 5);
               REG_DEST_PITCH:
                  value = $urandom_range(0, 16'hFFFF);
               // upper bits of the narrow fields are random too: the block must drop them
               default:
                  value = $urandom();
            endcase
            csr_write(reg_index_type'(i), value);
         end
      end
      settings_used++;
   endtask

   // hard stop if the block hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int words;
      expansion = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: no rows, so every word is an idle result at address zero
      send_word(16'h0000);
      send_word(16'hFFFF);
      wait_drained();
      settings_used++;

      // full-width rows at start bit zero, address wrapping past the top
      gaps_on   = 1'b1;
      csr_write(REG_FG_COLOR, 32'hFFFF_FFFF);
      csr_write(REG_BG_COLOR, 32'h0000_0000);
      csr_write(REG_USE_BACKGROUND, 32'd1);
      csr_write(REG_START_BIT, 32'd0);
      csr_write(REG_ROW_WIDTH, 32'd16);
      csr_write(REG_ROW_COUNT, 32'd2);
      csr_write(REG_DEST_START, 32'hFFFF_FFF8);
      csr_write(REG_DEST_PITCH, 32'h0000_FFFF);
      send_word(16'hFFFF);
      send_word(16'h0000);
      // block finished: idle result
      send_word(16'h5555);
      wait_drained();
      settings_used++;

      // last start bit, narrow rows spanning two words, clear bits skipped
      stalls_on = 1'b1;
      csr_write(REG_USE_BACKGROUND, 32'd0);
      csr_write(REG_START_BIT, 32'd15);
      csr_write(REG_ROW_WIDTH, 32'd3);
      csr_write(REG_ROW_COUNT, 32'd3);
      csr_write(REG_FG_COLOR, 32'h1234_5678);
      csr_write(REG_DEST_START, 32'd0);
      csr_write(REG_DEST_PITCH, 32'd0);
      send_word(16'h0001);
      send_word(16'h8000);
      send_word(16'h0000);
      send_word(16'h4000);
      wait_drained();
      settings_used++;

      // zero-width rows: one skip per word, then the block is over
      csr_write(REG_ROW_WIDTH, 32'd0);
      csr_write(REG_ROW_COUNT, 32'd2);
      send_word(16'hFFFF);
      send_word(16'h0000);
      send_word(16'hA5A5);
      wait_drained();
      settings_used++;

      // widest and tallest block, only the first words of it
      csr_write(REG_ROW_WIDTH, 32'd8191);
      csr_write(REG_ROW_COUNT, 32'd8191);
      csr_write(REG_START_BIT, 32'd7);
      send_word(16'hFFFF);
      send_word(16'h0000);
      send_word(16'h8001);
      wait_drained();
      settings_used++;

      // random phases: mostly whole blocks with random bitmaps, plus a few
      // spare idle words and some blocks cut short
      while (random_words < RANDOM_WORDS) begin
         random_setting();
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         words = int'(expansion.row_count) *
                 words_per_row(int'(expansion.start_bit), int'(expansion.row_width)) +
                 $urandom_range(0, 2);
         if (words > MAX_BURST)
            words = MAX_BURST;
         if (words == 0)
            words = 1;
         if ($urandom_range(0, 7) == 0)
            words = $urandom_range(1, words);
         repeat (words)
            send_word($urandom_range(0, 16'hFFFF));
         random_words += words;
         wait_drained();
      end

      $display("sent %0d bitmap words under %0d register settings",
               words_sent, settings_used);
      $display("checked %0d pixel results, %0d of them skips or idles",
               expansion.pixels_checked, expansion.quiet_results);
      if (expansion.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* mono_bitmap_color_expand_core.f */
src/mbce_pkg.sv
src/mbce_csr.sv
src/mbce_bit_shifter.sv
src/mbce_pos_track.sv
src/mono_bitmap_color_expand_core.sv
tb/sv/tb_top.sv
